### design/hcitp_pkg.sv
// Package for the H-curve index-to-point mapper: field widths, piece kind codes
// and the constant subdivision tables of the curve.
// Depends on nothing; used by h_curve_index_to_point_top and tb.
`default_nettype none

package hcitp_pkg;

    localparam int POS_W   = 32;
    localparam int COORD_W = 16;
    localparam int CFG_W   = 5;

    // Piece kinds: full squares A..D and half pieces X1, X2, Y1, Y2.
    // Bit 2 of a kind code marks a half piece.
    localparam logic [2:0] K_A  = 3'd0;
    localparam logic [2:0] K_B  = 3'd1;
    localparam logic [2:0] K_C  = 3'd2;
    localparam logic [2:0] K_D  = 3'd3;
    localparam logic [2:0] K_X1 = 3'd4;
    localparam logic [2:0] K_X2 = 3'd5;
    localparam logic [2:0] K_Y1 = 3'd6;
    localparam logic [2:0] K_Y2 = 3'd7;

    typedef struct packed {
        logic [2:0] kind;
        logic       half;
        logic       ox;
        logic       oy;
    } piece_t;

    localparam piece_t TOP_PARTS [4] = '{
        '{K_A, 1'b0, 1'b0, 1'b0}, '{K_B, 1'b0, 1'b0, 1'b1},
        '{K_C, 1'b0, 1'b1, 1'b1}, '{K_D, 1'b0, 1'b1, 1'b0}
    };

    // Full piece split: half, three full sub-squares, other half.
    localparam piece_t FULL_PARTS [4][5] = '{
        '{'{K_X1, 1'b0, 1'b1, 1'b1}, '{K_D, 1'b0, 1'b1, 1'b0}, '{K_A, 1'b0, 1'b0, 1'b0},
          '{K_B, 1'b0, 1'b0, 1'b1}, '{K_X1, 1'b1, 1'b1, 1'b1}},
        '{'{K_Y2, 1'b0, 1'b1, 1'b0}, '{K_A, 1'b0, 1'b0, 1'b0}, '{K_B, 1'b0, 1'b0, 1'b1},
          '{K_C, 1'b0, 1'b1, 1'b1}, '{K_Y2, 1'b1, 1'b1, 1'b0}},
        '{'{K_X2, 1'b0, 1'b0, 1'b0}, '{K_B, 1'b0, 1'b0, 1'b1}, '{K_C, 1'b0, 1'b1, 1'b1},
          '{K_D, 1'b0, 1'b1, 1'b0}, '{K_X2, 1'b1, 1'b0, 1'b0}},
        '{'{K_Y1, 1'b0, 1'b0, 1'b1}, '{K_C, 1'b0, 1'b1, 1'b1}, '{K_D, 1'b0, 1'b1, 1'b0},
          '{K_A, 1'b0, 1'b0, 1'b0}, '{K_Y1, 1'b1, 1'b0, 1'b1}}
    };

    // Half piece split: half, full, half. Indexed by kind, half flag, segment.
    localparam piece_t HALF_PARTS [4][2][3] = '{
        '{'{'{K_X1, 1'b0, 1'b1, 1'b1}, '{K_D, 1'b0, 1'b1, 1'b0}, '{K_X1, 1'b0, 1'b0, 1'b0}},
          '{'{K_X1, 1'b1, 1'b0, 1'b0}, '{K_B, 1'b0, 1'b0, 1'b1}, '{K_X1, 1'b1, 1'b1, 1'b1}}},
        '{'{'{K_X2, 1'b0, 1'b0, 1'b0}, '{K_B, 1'b0, 1'b0, 1'b1}, '{K_X2, 1'b0, 1'b1, 1'b1}},
          '{'{K_X2, 1'b1, 1'b1, 1'b1}, '{K_D, 1'b0, 1'b1, 1'b0}, '{K_X2, 1'b1, 1'b0, 1'b0}}},
        '{'{'{K_Y1, 1'b0, 1'b0, 1'b1}, '{K_C, 1'b0, 1'b1, 1'b1}, '{K_Y1, 1'b0, 1'b1, 1'b0}},
          '{'{K_Y1, 1'b1, 1'b1, 1'b0}, '{K_A, 1'b0, 1'b0, 1'b0}, '{K_Y1, 1'b1, 1'b0, 1'b1}}},
        '{'{'{K_Y2, 1'b0, 1'b1, 1'b0}, '{K_A, 1'b0, 1'b0, 1'b0}, '{K_Y2, 1'b0, 1'b0, 1'b1}},
          '{'{K_Y2, 1'b1, 1'b0, 1'b1}, '{K_C, 1'b0, 1'b1, 1'b1}, '{K_Y2, 1'b1, 1'b1, 1'b0}}}
    };

    // Base patterns: row 0 for A, D and all half pieces, row 1 for B and C.
    localparam logic BASE_X [2][4] = '{'{1'b1, 1'b1, 1'b0, 1'b0}, '{1'b0, 1'b0, 1'b1, 1'b1}};
    localparam logic BASE_Y [2][4] = '{'{1'b1, 1'b0, 1'b0, 1'b1}, '{1'b0, 1'b1, 1'b1, 1'b0}};

endpackage

`default_nettype wire

### design/h_curve_index_to_point_top.sv
// H-curve index-to-point mapper: a pipeline with one stage per curve level.
// Depends on hcitp_pkg for widths, kind codes and subdivision tables.
`default_nettype none

// m_valid rises once the item has passed stage 0, the level stages and the output
// register, whatever the configured level; unused stages just pass the item along.
// Throughput: one transaction per cycle; the pipeline advances whenever the output
// register is empty or being read, so a stall freezes every stage. Reset (synchronous,
// active low) empties the pipeline and sets the curve level to 2. Every stage reads the
// level register, so it must be written only while empty; the block does not check it.
module h_curve_index_to_point_top #(
    parameter int MAX_LEVEL = 16
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,

    input  wire logic                        cfg_wr_en,
    input  wire logic [hcitp_pkg::CFG_W-1:0] cfg_wr_data,

    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic [hcitp_pkg::POS_W-1:0] s_position,

    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic [hcitp_pkg::COORD_W-1:0]    m_coord_x,
    output logic [hcitp_pkg::COORD_W-1:0]    m_coord_y,
    output logic                             m_out_of_range
);

    // Index width: after the quadrant is taken, at most 2*(MAX_LEVEL-1) bits remain.
    localparam int IW   = 2 * MAX_LEVEL - 2;
    localparam int LW   = $clog2(MAX_LEVEL + 1);
    // Stage 0 picks the quadrant; stages 1..NSTG-1 each resolve one level.
    localparam int NSTG = MAX_LEVEL - 1;

    typedef struct packed {
        logic                 oor;
        logic [2:0]           kind;
        logic                 half;
        logic [IW-1:0]        idx;
        logic [MAX_LEVEL-1:0] x;
        logic [MAX_LEVEL-1:0] y;
    } stage_t;

    logic [LW-1:0] lvl_reg;
    stage_t        stg_reg [NSTG];
    logic          vld_reg [NSTG];
    logic          adv;

    logic                              out_vld_reg;
    logic [hcitp_pkg::COORD_W-1:0]     out_x_reg;
    logic [hcitp_pkg::COORD_W-1:0]     out_y_reg;
    logic                              out_oor_reg;

    // The whole pipeline moves together; it holds only when the result
    // register is full and the consumer is not taking it.
    assign adv     = !out_vld_reg || m_ready;
    assign s_ready = adv;

    // Level register. The written value is clamped into the supported range
    // here, so the datapath only ever sees a level from 2 to MAX_LEVEL.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lvl_reg <= LW'(2);
        end else if (cfg_wr_en) begin
            if (cfg_wr_data < hcitp_pkg::CFG_W'(2)) begin
                lvl_reg <= LW'(2);
            end else if (cfg_wr_data > hcitp_pkg::CFG_W'(MAX_LEVEL)) begin
                lvl_reg <= LW'(MAX_LEVEL);
            end else begin
                lvl_reg <= LW'(cfg_wr_data);
            end
        end
    end

    // Stage 0: range check and top-level quadrant selection. The quadrant is
    // the two position bits just above the remaining 2*(level-1) index bits.
    stage_t           top_next;
    hcitp_pkg::piece_t top_piece;
    logic [1:0]       top_quad;
    logic             top_oor;

    always_comb begin
        top_oor  = 1'b0;
        top_quad = 2'b00;
        for (int b = 0; b < hcitp_pkg::POS_W; b++) begin
            if (b >= 2 * int'(lvl_reg)) begin
                top_oor = top_oor | s_position[b];
            end
        end
        top_next      = '0;
        top_next.oor  = top_oor;
        for (int l = 2; l <= MAX_LEVEL; l++) begin
            if (lvl_reg == LW'(l)) begin
                top_quad     = s_position[2*l-1 -: 2];
            end
        end
        top_piece     = hcitp_pkg::TOP_PARTS[top_quad];
        top_next.kind = top_piece.kind;
        top_next.half = top_piece.half;
        for (int l = 2; l <= MAX_LEVEL; l++) begin
            if (lvl_reg == LW'(l)) begin
                top_next.idx  = s_position[IW-1:0] & ({IW{1'b1}} >> (IW - 2 * (l - 1)));
                top_next.x[l-2] = 1'b0;
                top_next.x[l-1] = top_piece.ox;
                top_next.y[l-1] = top_piece.oy;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg[0] <= 1'b0;
        end else if (adv) begin
            vld_reg[0] <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            stg_reg[0] <= top_next;
        end
    end

    // Level stages. Stage k resolves level N = MAX_LEVEL - k and only acts
    // when the configured level is above N; otherwise the item passes through.
    // Subtracting half a sub-square (HS) from the index makes the segment
    // readable from the top bits: for a full piece the top two bits give the
    // middle sub-squares, and an all-ones top picks a leading or trailing half.
    for (genvar k = 1; k < NSTG; k++) begin : g_lvl
        localparam int N = MAX_LEVEL - k;
        localparam logic [2*N-1:0] HS = (2*N)'(1) << (2 * N - 3);

        stage_t            cur;
        stage_t            nxt;
        hcitp_pkg::piece_t piece;
        logic [2*N-1:0]    t;
        logic [2:0]        seg;

        always_comb begin
            cur   = stg_reg[k-1];
            nxt   = cur;
            t     = cur.idx[2*N-1:0] - HS;
            seg   = 3'd0;
            piece = hcitp_pkg::FULL_PARTS[cur.kind[1:0]][0];
            if (lvl_reg > LW'(N)) begin
                if (!cur.kind[2]) begin
                    if (t[2*N-1:2*N-2] != 2'b11) begin
                        seg = 3'(t[2*N-1:2*N-2]) + 3'd1;
                    end else begin
                        seg = t[2*N-3] ? 3'd0 : 3'd4;
                    end
                    piece = hcitp_pkg::FULL_PARTS[cur.kind[1:0]][seg];
                end else begin
                    if (!t[2*N-2]) begin
                        seg = 3'd1;
                    end else begin
                        seg = t[2*N-3] ? 3'd0 : 3'd2;
                    end
                    piece = hcitp_pkg::HALF_PARTS[cur.kind[1:0]][cur.half][seg[1:0]];
                end
                nxt.idx             = '0;
                nxt.idx[2*N-3:0]    = t[2*N-3:0];
                // A leading half starts below HS: drop the borrowed HS bit.
                if (seg == 3'd0) begin
                    nxt.idx[2*N-3] = 1'b0;
                end
                nxt.kind   = piece.kind;
                nxt.half   = piece.half;
                nxt.x[N-1] = cur.x[N-1] | piece.ox;
                nxt.y[N-1] = cur.y[N-1] | piece.oy;
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (adv) begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                stg_reg[k] <= nxt;
            end
        end
    end

    // Final stage: the two- or four-point base pattern sets coordinate bit 0.
    stage_t               fin;
    logic                 pat;
    logic [1:0]           bi;
    logic [MAX_LEVEL-1:0] fin_x;
    logic [MAX_LEVEL-1:0] fin_y;

    always_comb begin
        fin = stg_reg[NSTG-1];
        if (!fin.kind[2]) begin
            pat = (fin.kind == hcitp_pkg::K_B) || (fin.kind == hcitp_pkg::K_C);
            bi  = fin.idx[1:0];
        end else begin
            pat = 1'b0;
            bi  = {fin.half ^ ((fin.kind == hcitp_pkg::K_X2) || (fin.kind == hcitp_pkg::K_Y2)),
                   fin.idx[0]};
        end
        fin_x    = fin.x;
        fin_y    = fin.y;
        fin_x[0] = hcitp_pkg::BASE_X[pat][bi];
        fin_y[0] = hcitp_pkg::BASE_Y[pat][bi];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (adv) begin
            out_vld_reg <= vld_reg[NSTG-1];
        end
    end

    // Out-of-range items report zero coordinates.
    always_ff @(posedge aclk) begin
        if (adv) begin
            out_oor_reg <= fin.oor;
            out_x_reg   <= fin.oor ? '0 : hcitp_pkg::COORD_W'(fin_x);
            out_y_reg   <= fin.oor ? '0 : hcitp_pkg::COORD_W'(fin_y);
        end
    end

    assign m_valid        = out_vld_reg;
    assign m_coord_x      = out_x_reg;
    assign m_coord_y      = out_y_reg;
    assign m_out_of_range = out_oor_reg;

    // An accepted transaction always lands in the first stage.
    a_enter: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> vld_reg[0])
        else $error("accepted transaction missing from stage 0");

    // By the base stage an in-range index fits the four-point pattern.
    a_base_idx: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[NSTG-1] && !stg_reg[NSTG-1].oor |-> (stg_reg[NSTG-1].idx >> 2) == '0)
        else $error("index not reduced to base pattern");

    // A point lies inside the grid of the configured level.
    a_in_grid: assert property (@(posedge aclk) disable iff (!aresetn)
        out_vld_reg && !out_oor_reg |->
            ((32'(out_x_reg) >> lvl_reg) == 32'd0) && ((32'(out_y_reg) >> lvl_reg) == 32'd0))
        else $error("coordinate outside grid");

    // Out-of-range results carry zero coordinates.
    a_oor_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        out_vld_reg && out_oor_reg |-> (out_x_reg == '0) && (out_y_reg == '0))
        else $error("out-of-range result with nonzero coordinates");

endmodule

`default_nettype wire

### tb/tb.sv
// Self-checking testbench for h_curve_index_to_point_top: directed table, then random phases.
// Carries its own H-curve point predictor; depends on hcitp_pkg for widths and kind codes.
`timescale 1ns / 1ps

module tb;

    localparam int MAX_LEVEL       = 16;
    localparam int PHASES          = 10;
    localparam int ITEMS_PER_PHASE = 60;
    localparam int N_DIRECTED      = 24;

    // Widths and kind codes shared with the block.
    localparam int POS_W   = hcitp_pkg::POS_W;
    localparam int COORD_W = hcitp_pkg::COORD_W;
    localparam int CFG_W   = hcitp_pkg::CFG_W;

    localparam logic [2:0] K_A  = hcitp_pkg::K_A;
    localparam logic [2:0] K_B  = hcitp_pkg::K_B;
    localparam logic [2:0] K_C  = hcitp_pkg::K_C;
    localparam logic [2:0] K_D  = hcitp_pkg::K_D;
    localparam logic [2:0] K_X1 = hcitp_pkg::K_X1;
    localparam logic [2:0] K_X2 = hcitp_pkg::K_X2;
    localparam logic [2:0] K_Y1 = hcitp_pkg::K_Y1;
    localparam logic [2:0] K_Y2 = hcitp_pkg::K_Y2;

    // One grid point as the block reports it.
    typedef struct packed {
        logic [COORD_W-1:0] coord_x;
        logic [COORD_W-1:0] coord_y;
        logic               out_of_range;
    } point_t;

    // One sub-piece of a split: its kind, which half it is, and its quadrant offset.
    typedef struct packed {
        logic [2:0] kind;
        logic       half;
        logic       ox;
        logic       oy;
    } split_t;

    // One row of the directed table. Rows with hand_checked set carry a result
    // worked out by hand; the rest are checked against the predictor.
    typedef struct packed {
        logic [CFG_W-1:0] level;
        logic [POS_W-1:0] position;
        logic             hand_checked;
        point_t           want;
    } probe_t;

    localparam point_t PAST_END = '{16'd0, 16'd0, 1'b1};
    localparam point_t NO_POINT = '0;

    // Top-level order of the four quadrants: lower left, upper left, upper right, lower right.
    localparam split_t TOP_SPLIT [4] = '{
        '{K_A, 1'b0, 1'b0, 1'b0}, '{K_B, 1'b0, 1'b0, 1'b1},
        '{K_C, 1'b0, 1'b1, 1'b1}, '{K_D, 1'b0, 1'b1, 1'b0}
    };

    // A full piece splits into a half piece, three full sub-squares and the other half.
    localparam split_t FULL_SPLIT [4][5] = '{
        '{'{K_X1, 1'b0, 1'b1, 1'b1}, '{K_D, 1'b0, 1'b1, 1'b0}, '{K_A, 1'b0, 1'b0, 1'b0},
          '{K_B, 1'b0, 1'b0, 1'b1}, '{K_X1, 1'b1, 1'b1, 1'b1}},
        '{'{K_Y2, 1'b0, 1'b1, 1'b0}, '{K_A, 1'b0, 1'b0, 1'b0}, '{K_B, 1'b0, 1'b0, 1'b1},
          '{K_C, 1'b0, 1'b1, 1'b1}, '{K_Y2, 1'b1, 1'b1, 1'b0}},
        '{'{K_X2, 1'b0, 1'b0, 1'b0}, '{K_B, 1'b0, 1'b0, 1'b1}, '{K_C, 1'b0, 1'b1, 1'b1},
          '{K_D, 1'b0, 1'b1, 1'b0}, '{K_X2, 1'b1, 1'b0, 1'b0}},
        '{'{K_Y1, 1'b0, 1'b0, 1'b1}, '{K_C, 1'b0, 1'b1, 1'b1}, '{K_D, 1'b0, 1'b1, 1'b0},
          '{K_A, 1'b0, 1'b0, 1'b0}, '{K_Y1, 1'b1, 1'b0, 1'b1}}
    };

    // A half piece splits into half, full, half; indexed by kind, half flag and segment.
    localparam split_t HALF_SPLIT [4][2][3] = '{
        '{'{'{K_X1, 1'b0, 1'b1, 1'b1}, '{K_D, 1'b0, 1'b1, 1'b0}, '{K_X1, 1'b0, 1'b0, 1'b0}},
          '{'{K_X1, 1'b1, 1'b0, 1'b0}, '{K_B, 1'b0, 1'b0, 1'b1}, '{K_X1, 1'b1, 1'b1, 1'b1}}},
        '{'{'{K_X2, 1'b0, 1'b0, 1'b0}, '{K_B, 1'b0, 1'b0, 1'b1}, '{K_X2, 1'b0, 1'b1, 1'b1}},
          '{'{K_X2, 1'b1, 1'b1, 1'b1}, '{K_D, 1'b0, 1'b1, 1'b0}, '{K_X2, 1'b1, 1'b0, 1'b0}}},
        '{'{'{K_Y1, 1'b0, 1'b0, 1'b1}, '{K_C, 1'b0, 1'b1, 1'b1}, '{K_Y1, 1'b0, 1'b1, 1'b0}},
          '{'{K_Y1, 1'b1, 1'b1, 1'b0}, '{K_A, 1'b0, 1'b0, 1'b0}, '{K_Y1, 1'b1, 1'b0, 1'b1}}},
        '{'{'{K_Y2, 1'b0, 1'b1, 1'b0}, '{K_A, 1'b0, 1'b0, 1'b0}, '{K_Y2, 1'b0, 1'b0, 1'b1}},
          '{'{K_Y2, 1'b1, 1'b0, 1'b1}, '{K_C, 1'b0, 1'b1, 1'b1}, '{K_Y2, 1'b1, 1'b1, 1'b0}}}
    };

    // Offsets inside the final 2x2 cell: row 0 for A, D and half pieces, row 1 for B and C.
    localparam logic CORNER_X [2][4] = '{'{1'b1, 1'b1, 1'b0, 1'b0}, '{1'b0, 1'b0, 1'b1, 1'b1}};
    localparam logic CORNER_Y [2][4] = '{'{1'b1, 1'b0, 1'b0, 1'b1}, '{1'b0, 1'b1, 1'b1, 1'b0}};

    // Directed table. It starts at the reset level with no register write, so the
    // first rows also show that the level comes out of reset as 2. Levels 0, 1, 17
    // and 31 lie outside the legal range and must behave as 2 or as the maximum.
    localparam probe_t DIRECTED [N_DIRECTED] = '{
        '{5'd2,  32'h0000_0000, 1'b1, '{16'd1, 16'd1, 1'b0}},
        '{5'd2,  32'h0000_000F, 1'b1, '{16'd2, 16'd1, 1'b0}},
        '{5'd2,  32'h0000_0010, 1'b1, PAST_END},
        '{5'd2,  32'hFFFF_FFFF, 1'b1, PAST_END},
        '{5'd2,  32'h0000_0006, 1'b0, NO_POINT},
        '{5'd0,  32'h0000_000F, 1'b1, '{16'd2, 16'd1, 1'b0}},
        '{5'd0,  32'h0000_0010, 1'b1, PAST_END},
        '{5'd1,  32'h0000_0003, 1'b0, NO_POINT},
        '{5'd1,  32'h0000_0010, 1'b1, PAST_END},
        '{5'd3,  32'h0000_0000, 1'b0, NO_POINT},
        '{5'd3,  32'h0000_0025, 1'b0, NO_POINT},
        '{5'd3,  32'h0000_003F, 1'b0, NO_POINT},
        '{5'd3,  32'h0000_0040, 1'b1, PAST_END},
        '{5'd5,  32'h0000_03FF, 1'b0, NO_POINT},
        '{5'd5,  32'h0000_0400, 1'b1, PAST_END},
        '{5'd15, 32'h3FFF_FFFF, 1'b0, NO_POINT},
        '{5'd15, 32'h4000_0000, 1'b1, PAST_END},
        '{5'd16, 32'h0000_0000, 1'b0, NO_POINT},
        '{5'd16, 32'hFFFF_FFFF, 1'b0, NO_POINT},
        '{5'd16, 32'h8000_0000, 1'b0, NO_POINT},
        '{5'd16, 32'h5555_5555, 1'b0, NO_POINT},
        '{5'd17, 32'hFFFF_FFFF, 1'b0, NO_POINT},
        '{5'd17, 32'hAAAA_AAAA, 1'b0, NO_POINT},
        '{5'd31, 32'h1234_5678, 1'b0, NO_POINT}
    };

    // Clock and reset. Reset is held low only at the start of the run.
    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    always #10 aclk = ~aclk;

    // Every input of the block has a known value from time zero.
    logic               cfg_wr_en   = 1'b0;
    logic [CFG_W-1:0]   cfg_wr_data = '0;
    logic               s_valid     = 1'b0;
    logic               s_ready;
    logic [POS_W-1:0]   s_position  = '0;
    logic               m_valid;
    logic               m_ready     = 1'b0;
    logic [COORD_W-1:0] m_coord_x;
    logic [COORD_W-1:0] m_coord_y;
    logic               m_out_of_range;

    // Testbench copy of the level register, updated at the edge that writes it.
    logic [CFG_W-1:0] level_shadow = 5'd2;
    // Points still owed by the block, oldest first.
    point_t           pending_points [$];
    int               mismatch_count = 0;
    // While set, both the sender and the receiver insert random idle bursts.
    bit               idle_on = 1'b1;

    h_curve_index_to_point_top #(
        .MAX_LEVEL(MAX_LEVEL)
    ) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_position    (s_position),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_coord_x     (m_coord_x),
        .m_coord_y     (m_coord_y),
        .m_out_of_range(m_out_of_range)
    );

    // The level actually used: values below 2 act as 2, values above the maximum
    // act as the maximum.
    function automatic int unsigned effective_level(input logic [CFG_W-1:0] level_cfg);
        int unsigned lvl;
        lvl = 32'(level_cfg);
        if (lvl < 2) lvl = 2;
        if (lvl > MAX_LEVEL) lvl = MAX_LEVEL;
        return lvl;
    endfunction

    // Walks the curve from the top quadrant down to the 2x2 cell, adding the offset
    // of each chosen sub-piece, and returns the point at the given position.
    function automatic point_t curve_point(input logic [CFG_W-1:0] level_cfg,
                                           input logic [POS_W-1:0] pos);
        int unsigned lvl, n, seg;
        logic [63:0] idx, q, hs;
        logic [2:0]  kind;
        logic        half, row;
        logic [1:0]  corner;
        logic [31:0] x, y;
        split_t      part;
        point_t      pt;
        lvl = effective_level(level_cfg);
        pt = '0;
        if (64'(pos) >= (64'd1 << (2 * lvl))) begin
            pt.out_of_range = 1'b1;
            return pt;
        end
        n = lvl - 1;
        part = TOP_SPLIT[pos[2 * n +: 2]];
        idx = 64'(pos) & ((64'd1 << (2 * n)) - 64'd1);
        kind = part.kind;
        half = part.half;
        x = 32'(part.ox) << n;
        y = 32'(part.oy) << n;
        while (n > 1) begin
            // q points in a full sub-square, half as many in a half piece.
            q = 64'd1 << (2 * (n - 1));
            hs = q >> 1;
            if (!kind[2]) begin
                if (idx < hs) begin
                    seg = 0;
                end else if (idx < hs + 3 * q) begin
                    seg = 1 + int'((idx - hs) / q);
                    idx = idx - hs - 64'(seg - 1) * q;
                end else begin
                    seg = 4;
                    idx = idx - hs - 3 * q;
                end
                part = FULL_SPLIT[kind[1:0]][seg];
            end else begin
                if (idx < hs) begin
                    seg = 0;
                end else if (idx < hs + q) begin
                    seg = 1;
                    idx = idx - hs;
                end else begin
                    seg = 2;
                    idx = idx - hs - q;
                end
                part = HALF_SPLIT[kind[1:0]][half][seg];
            end
            n--;
            kind = part.kind;
            half = part.half;
            x += 32'(part.ox) << n;
            y += 32'(part.oy) << n;
        end
        if (!kind[2]) begin
            row = (kind == K_B || kind == K_C);
            corner = idx[1:0];
        end else begin
            // A half piece covers two points of the cell; which two depends on
            // its half flag, flipped for the second type of each pair.
            row = 1'b0;
            corner = {half ^ (kind == K_X2 || kind == K_Y2), idx[0]};
        end
        x += 32'(CORNER_X[row][corner]);
        y += 32'(CORNER_Y[row][corner]);
        pt.coord_x = x[COORD_W-1:0];
        pt.coord_y = y[COORD_W-1:0];
        return pt;
    endfunction

    // Random positions: mostly inside the curve so the whole split walk is
    // exercised, some past the end with random high bits, and a few on the edges.
    function automatic logic [POS_W-1:0] pick_position(input int unsigned lvl);
        logic [63:0] span;
        int unsigned roll;
        span = 64'd1 << (2 * lvl);
        roll = $urandom_range(0, 19);
        if (roll == 17) return 32'(span - 64'd1);
        if (roll == 19) return '0;
        if (lvl < MAX_LEVEL && roll == 18) return 32'(span);
        if (lvl < MAX_LEVEL && roll >= 15) return $urandom | 32'(span);
        return $urandom & 32'(span - 64'd1);
    endfunction

    task automatic log_mismatch(input string why, input point_t want);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%0t: %s: expected x=%0d y=%0d oor=%0b, got x=%0d y=%0d oor=%0b",
                     $time, why, want.coord_x, want.coord_y, want.out_of_range,
                     m_coord_x, m_coord_y, m_out_of_range);
    endtask

    // Waits until the block has handed back every owed point, then writes the
    // level register. The caller returns here in the step of the last accepted
    // transaction, so valid is lowered first, in that same step.
    task automatic program_level(input logic [CFG_W-1:0] lvl);
        s_valid <= 1'b0;
        while (pending_points.size() != 0) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= lvl;
        @(posedge aclk);
        cfg_wr_en    <= 1'b0;
        level_shadow = lvl;
    endtask

    // Offers one position and returns in the step where it is accepted. Valid is
    // only lowered when an idle burst goes in front of the next transaction.
    task automatic send_position(input logic [POS_W-1:0] pos, input logic hand_checked,
                                 input point_t want);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_position <= pos;
        do @(posedge aclk); while (!s_ready);
        pending_points.push_back(hand_checked ? want : curve_point(level_shadow, pos));
    endtask

    // Receiver: ready drops in random bursts while idling is on.
    initial begin
        int hold;
        hold = 0;
        forever begin
            @(posedge aclk);
            if (hold > 0) begin
                hold--;
                m_ready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                hold = $urandom_range(1, 6) - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Result checker: every accepted transaction on the result side is compared
    // with the oldest owed point. Values are sampled as they stood before the edge.
    always @(posedge aclk) begin
        point_t got;
        if (aresetn && m_valid && m_ready) begin
            got = '{m_coord_x, m_coord_y, m_out_of_range};
            if (pending_points.size() == 0) begin
                log_mismatch("result with none owed", NO_POINT);
            end else begin
                if (got !== pending_points[0]) log_mismatch("wrong point", pending_points[0]);
                void'(pending_points.pop_front());
            end
        end
    end

    // Main sequence: reset, directed table, random phases, drain, verdict.
    initial begin
        logic [CFG_W-1:0] lvl;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < N_DIRECTED; i++) begin
            if (DIRECTED[i].level != level_shadow) program_level(DIRECTED[i].level);
            send_position(DIRECTED[i].position, DIRECTED[i].hand_checked, DIRECTED[i].want);
        end

        // Random phases. The first three pin the maximum level, the reset level
        // and the top code; the rest mostly pick legal levels. The last phase runs
        // with no idling at all, so back-to-back streaming is seen too.
        for (int ph = 0; ph < PHASES; ph++) begin
            if (ph == 0) lvl = 5'd16;
            else if (ph == 1) lvl = 5'd2;
            else if (ph == 2) lvl = 5'd31;
            else if ($urandom_range(0, 3) == 0) lvl = 5'($urandom_range(0, 31));
            else lvl = 5'($urandom_range(2, 16));
            program_level(lvl);
            idle_on = (ph == PHASES - 1) ? 1'b0 : ($urandom_range(0, 3) != 0);
            repeat (ITEMS_PER_PHASE)
                send_position(pick_position(effective_level(level_shadow)), 1'b0, NO_POINT);
        end

        s_valid <= 1'b0;
        while (pending_points.size() != 0) @(posedge aclk);
        // A little longer than the pipeline depth, to catch stray results.
        repeat (MAX_LEVEL + 4) @(posedge aclk);

        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #5_000_000;
        if (pending_points.size() != 0)
            $display("%0d results never arrived", pending_points.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

### files.f
design/hcitp_pkg.sv
design/h_curve_index_to_point_top.sv
tb/tb.sv
